>>> hw/rtl/stlg_pkg.sv
`default_nettype none

package stlg_pkg;

  localparam int MaxSites   = 16;
  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int SizeW      = IdxW + 1;
  localparam int SiteCntW   = 5;
  localparam int ColW       = 10;
  localparam int EntryW     = 2 * MaxSites;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = SizeW;
  localparam int JqDepth    = 2;
  localparam int JqPtrW     = $clog2(JqDepth);
  localparam int JqCntW     = $clog2(JqDepth + 1);

  localparam logic [SiteCntW-1:0] SiteCountReset = SiteCntW'(8);
  localparam logic [SizeW-1:0]    TableSizeReset = '0;

  typedef enum logic {
    ReqLoad  = 1'b0,
    ReqApply = 1'b1
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSiteCount = 1'b0,
    CfgTableSize = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackSearch,
    BackEmit
  } back_state_e;

  typedef struct packed {
    logic [MaxSites-1:0] up;
    logic [MaxSites-1:0] dn;
    logic [ColW-1:0]     col;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jq_status_t;

  typedef struct packed {
    logic            term_valid;
    logic [IdxW-1:0] target_index;
    logic            found;
    logic            sign_negative;
    logic [ColW-1:0] source_column;
    logic            last;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/stlg_ram.sv
`default_nettype none

module stlg_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/stlg_job_queue.sv
`default_nettype none

module stlg_job_queue
  import stlg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire job_t       data_i,
  input  wire logic       pop_i,
  output      job_t       data_o,
  output      jq_status_t status_o
);

  job_t              mem_q [JqDepth];
  logic [JqPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [JqPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [JqCntW-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == JqCntW'(JqDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = JqPtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = JqPtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = JqCntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = JqCntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stlg_front.sv
`default_nettype none

module stlg_front
  import stlg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output      logic                full_o,
  input  wire logic                req_type_i,
  input  wire logic [IdxW-1:0]     entry_index_i,
  input  wire logic [MaxSites-1:0] up_state_i,
  input  wire logic [MaxSites-1:0] down_state_i,
  input  wire logic [ColW-1:0]     column_index_i,
  input  wire logic [SiteCntW-1:0] site_count_i,
  input  wire logic                back_idle_i,
  input  wire jq_status_t          jq_status_i,
  output      logic                jq_push_o,
  output      job_t                jq_data_o,
  output      logic                ram_we_o,
  output      logic [IdxW-1:0]     ram_waddr_o,
  output      logic [EntryW-1:0]   ram_wdata_o
);

  logic                valid_q, valid_d;
  req_e                req_q;
  logic [IdxW-1:0]     idx_q;
  logic [MaxSites-1:0] up_q, dn_q;
  logic [ColW-1:0]     col_q;
  logic [SiteCntW-1:0] sites;
  logic [MaxSites-1:0] site_mask;
  logic                dispatch, accept;

  assign sites = (site_count_i > SiteCntW'(MaxSites)) ? SiteCntW'(MaxSites) : site_count_i;

  always_comb begin
    for (int k = 0; k < MaxSites; k++) begin
      site_mask[k] = (SiteCntW'(k) < sites);
    end
  end

  always_comb begin
    dispatch = 1'b0;
    if (valid_q) begin
      unique case (req_q)
        ReqApply: dispatch = !jq_status_i.full;
        ReqLoad:  dispatch = jq_status_i.empty && back_idle_i;
      endcase
    end
  end

  assign full_o    = valid_q && !dispatch;
  assign accept    = push_i && !full_o;
  assign jq_push_o = dispatch && (req_q == ReqApply);
  assign ram_we_o  = dispatch && (req_q == ReqLoad);

  assign jq_data_o.up  = up_q & site_mask;
  assign jq_data_o.dn  = dn_q & site_mask;
  assign jq_data_o.col = col_q;
  assign ram_waddr_o   = idx_q;
  assign ram_wdata_o   = {up_q, dn_q};

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (dispatch) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(req_type_i);
      idx_q <= entry_index_i;
      up_q  <= up_state_i;
      dn_q  <= down_state_i;
      col_q <= column_index_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stlg_back.sv
`default_nettype none

module stlg_back
  import stlg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SizeW-1:0]  table_size_i,
  input  wire jq_status_t        jq_status_i,
  input  wire job_t              jq_data_i,
  output      logic              jq_pop_o,
  output      logic [IdxW-1:0]   ram_raddr_o,
  input  wire logic [EntryW-1:0] ram_rdata_i,
  input  wire logic              pop_i,
  output      result_t           result_o,
  output      logic              res_valid_o,
  output      logic              back_idle_o
);

  back_state_e         state_q, state_d;
  logic [MaxSites-1:0] up_q, up_d, dn_q, dn_d, rem_q, rem_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [SizeW-1:0]    rd_idx_q, rd_idx_d;
  logic                cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic                hit_q, hit_d;
  logic [IdxW-1:0]     hit_idx_q, hit_idx_d;
  result_t             res_q, res_d;
  logic                res_valid_q, res_valid_d;
  logic [SizeW-1:0]    limit;
  logic [MaxSites-1:0] site_oh, below, rem_next, job_rem;
  logic [EntryW-1:0]   key;
  logic                parity, res_free, res_load;

  assign limit    = (table_size_i > SizeW'(TableDepth)) ? SizeW'(TableDepth) : table_size_i;
  assign site_oh  = rem_q & (~rem_q + 1'b1);
  assign below    = site_oh - 1'b1;
  assign key      = {up_q ^ site_oh, dn_q | site_oh};
  assign parity   = ^((dn_q & ~below) ^ (up_q & below));
  assign rem_next = rem_q & ~site_oh;
  assign job_rem  = jq_data_i.up & ~jq_data_i.dn;
  assign res_free = !res_valid_q || pop_i;

  assign ram_raddr_o = rd_idx_q[IdxW-1:0];
  assign back_idle_o = (state_q == BackIdle);
  assign result_o    = res_q;
  assign res_valid_o = res_valid_q;

  always_comb begin
    state_d     = state_q;
    up_d        = up_q;
    dn_d        = dn_q;
    col_d       = col_q;
    rem_d       = rem_q;
    rd_idx_d    = rd_idx_q;
    cmp_valid_d = cmp_valid_q;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    jq_pop_o    = 1'b0;
    res_load    = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (!jq_status_i.empty) begin
          jq_pop_o    = 1'b1;
          up_d        = jq_data_i.up;
          dn_d        = jq_data_i.dn;
          col_d       = jq_data_i.col;
          rem_d       = job_rem;
          rd_idx_d    = '0;
          cmp_valid_d = 1'b0;
          hit_d       = 1'b0;
          hit_idx_d   = '0;
          state_d     = (job_rem == '0) ? BackEmit : BackSearch;
        end
      end
      BackSearch: begin
        if (cmp_valid_q && (ram_rdata_i == key)) begin
          hit_d       = 1'b1;
          hit_idx_d   = cmp_idx_q;
          cmp_valid_d = 1'b0;
          state_d     = BackEmit;
        end else if (rd_idx_q < limit) begin
          cmp_valid_d = 1'b1;
          cmp_idx_d   = rd_idx_q[IdxW-1:0];
          rd_idx_d    = SizeW'(rd_idx_q + 1'b1);
        end else if (!cmp_valid_q) begin
          state_d = BackEmit;
        end else begin
          cmp_valid_d = 1'b0;
        end
      end
      BackEmit: begin
        if (res_free) begin
          res_load    = 1'b1;
          rem_d       = rem_next;
          rd_idx_d    = '0;
          cmp_valid_d = 1'b0;
          hit_d       = 1'b0;
          hit_idx_d   = '0;
          state_d     = (rem_next == '0) ? BackIdle : BackSearch;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_comb begin
    res_d.term_valid    = (rem_q != '0);
    res_d.target_index  = hit_idx_q;
    res_d.found         = hit_q;
    res_d.sign_negative = (rem_q != '0) && parity;
    res_d.source_column = col_q;
    res_d.last          = (rem_next == '0);
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      cmp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= cmp_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q      <= up_d;
    dn_q      <= dn_d;
    col_q     <= col_d;
    rem_q     <= rem_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/spin_lowering_term_generator_unit.sv
// Spin-lowering term generator.
// Input queue side: push/full, one beat per item. A load beat writes one entry of
// the 1024-entry basis table; an apply beat brings a source state and yields one
// result beat per site whose up bit is set and down bit is clear, lowest site first,
// or a single empty result if there is none. The final result of an apply has last set.
// Result queue side: empty/pop; the oldest result is on the ports while empty is low.
// Configuration: cfg_valid_i/cfg_ready_o with a register index and data; ready is
// always high. Write only while the block is idle.
// Flow: an item is held in the front register; an apply then waits in a two-entry
// job queue. For each term the back end reads one table entry per cycle from the
// single read port, up to min(table_size, 1024) entries, and stops at the first
// match; the result is then placed in the result register. A load waits until all
// earlier applies have left the search. A stalled receiver holds the result
// register; the search then halts, and the front keeps taking items until the job
// queue and the front register are full, or a load waits in the front register.
// Reset clears the control state, sets eight sites and an empty table size; the
// table contents stay undefined until loaded.
`default_nettype none

module spin_lowering_term_generator_unit
  import stlg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output      logic                full,
  input  wire logic                req_type_i,
  input  wire logic [IdxW-1:0]     entry_index_i,
  input  wire logic [MaxSites-1:0] up_state_i,
  input  wire logic [MaxSites-1:0] down_state_i,
  input  wire logic [ColW-1:0]     column_index_i,
  output      logic                empty,
  input  wire logic                pop,
  output      logic                term_valid_o,
  output      logic [IdxW-1:0]     target_index_o,
  output      logic                found_o,
  output      logic                sign_negative_o,
  output      logic [ColW-1:0]     source_column_o,
  output      logic                last_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [SiteCntW-1:0] site_count_q, site_count_d;
  logic [SizeW-1:0]    table_size_q, table_size_d;
  logic                back_idle, jq_push, jq_pop, ram_we, res_valid;
  jq_status_t          jq_status;
  job_t                jq_in, jq_out;
  logic [IdxW-1:0]     ram_waddr, ram_raddr;
  logic [EntryW-1:0]   ram_wdata, ram_rdata;
  result_t             result;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    site_count_d = site_count_q;
    table_size_d = table_size_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgSiteCount: site_count_d = cfg_data_i[SiteCntW-1:0];
        CfgTableSize: table_size_d = cfg_data_i[SizeW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_count_q <= SiteCountReset;
      table_size_q <= TableSizeReset;
    end else begin
      site_count_q <= site_count_d;
      table_size_q <= table_size_d;
    end
  end

  stlg_front u_front (
    .clk_i,
    .rst_ni,
    .push_i         (push),
    .full_o         (full),
    .req_type_i,
    .entry_index_i,
    .up_state_i,
    .down_state_i,
    .column_index_i,
    .site_count_i   (site_count_q),
    .back_idle_i    (back_idle),
    .jq_status_i    (jq_status),
    .jq_push_o      (jq_push),
    .jq_data_o      (jq_in),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata)
  );

  stlg_job_queue u_job_queue (
    .clk_i,
    .rst_ni,
    .push_i   (jq_push),
    .data_i   (jq_in),
    .pop_i    (jq_pop),
    .data_o   (jq_out),
    .status_o (jq_status)
  );

  stlg_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stlg_back u_back (
    .clk_i,
    .rst_ni,
    .table_size_i (table_size_q),
    .jq_status_i  (jq_status),
    .jq_data_i    (jq_out),
    .jq_pop_o     (jq_pop),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .pop_i        (pop),
    .result_o     (result),
    .res_valid_o  (res_valid),
    .back_idle_o  (back_idle)
  );

  assign empty           = !res_valid;
  assign term_valid_o    = result.term_valid;
  assign target_index_o  = result.target_index;
  assign found_o         = result.found;
  assign sign_negative_o = result.sign_negative;
  assign source_column_o = result.source_column;
  assign last_o          = result.last;

`ifndef SYNTHESIS
  a_load_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (back_idle && jq_status.empty))
    else $error("table written while a search may be running");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jq_push |-> !jq_status.full)
    else $error("job queue pushed while full");

  a_empty_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !term_valid_o) |-> (last_o && !found_o && !sign_negative_o))
    else $error("result without a term is malformed");
`endif

endmodule

`default_nettype wire
